[rtl/hsl2rgb_pkg.sv]
package hsl2rgb_pkg;

    localparam int UNIT_FRAC_BITS = 12;
    localparam int HUE_FRAC_BITS  = 6;

    localparam int HUE_W  = HUE_FRAC_BITS + 9;
    localparam int UNIT_W = UNIT_FRAC_BITS + 1;
    localparam int CHAN_W = 8;

    // Signed widths of the intermediate terms.
    localparam int A_W  = UNIT_FRAC_BITS + 3;
    localparam int K_W  = HUE_FRAC_BITS + 8;
    localparam int CN_W = 2 * UNIT_FRAC_BITS + 3;
    localparam int N_W  = 2 * UNIT_FRAC_BITS + HUE_FRAC_BITS + 10;
    localparam int M_W  = N_W + 5;

    // 255 / 60 reduces to 17 / 4, so every channel is 17 * N / 2^OUT_SHIFT.
    localparam int OUT_SHIFT = 2 * UNIT_FRAC_BITS + HUE_FRAC_BITS + 3;
    localparam int Q_W       = M_W - OUT_SHIFT;
    localparam int BASE_SH   = UNIT_FRAC_BITS + HUE_FRAC_BITS;

    localparam int SECTOR      = 60 * (1 << HUE_FRAC_BITS);
    localparam int UNIT_ONE    = 1 << UNIT_FRAC_BITS;
    localparam int LIGHT_SCALE = 120;
    localparam int CHAN_MAX    = 255;

    typedef enum logic [1:0] {
        SEL_ZERO = 2'd0,
        SEL_C    = 2'd1,
        SEL_X    = 2'd2
    } t_comp_sel;

    typedef struct packed {
        logic [HUE_W-1:0]  hue;
        logic [UNIT_W-1:0] saturation;
        logic [UNIT_W-1:0] lightness;
    } t_hsl_req;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } t_rgb_result;

    typedef struct packed {
        t_comp_sel red;
        t_comp_sel green;
        t_comp_sel blue;
    } t_sel_set;

    typedef struct packed {
        logic                  valid;
        logic signed [A_W-1:0] a;
        logic [UNIT_W-1:0]     s;
        logic [UNIT_W-1:0]     l;
        logic signed [K_W-1:0] k;
        t_sel_set              sel;
    } t_front_stage;

    typedef struct packed {
        logic                  valid;
        logic signed [N_W-1:0] p;
        logic signed [N_W-1:0] cd;
        logic signed [N_W-1:0] base;
        t_sel_set              sel;
    } t_prod_stage;

endpackage

[rtl/hsl2rgb_front.sv]
module hsl2rgb_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  hsl2rgb_pkg::t_hsl_req i_req,
    output hsl2rgb_pkg::t_front_stage o_stage
);
    import hsl2rgb_pkg::*;

    localparam logic [HUE_W-1:0] TH1 = HUE_W'(SECTOR);
    localparam logic [HUE_W-1:0] TH2 = HUE_W'(2 * SECTOR);
    localparam logic [HUE_W-1:0] TH3 = HUE_W'(3 * SECTOR);
    localparam logic [HUE_W-1:0] TH4 = HUE_W'(4 * SECTOR);
    localparam logic [HUE_W-1:0] TH5 = HUE_W'(5 * SECTOR);
    localparam logic [HUE_W-1:0] TH6 = HUE_W'(6 * SECTOR);
    localparam logic [HUE_W-1:0] TH8 = HUE_W'(8 * SECTOR);
    localparam logic signed [K_W-1:0] K_SECTOR = K_W'(SECTOR);
    localparam logic signed [A_W-1:0] A_UNIT   = A_W'(UNIT_ONE);

    logic [HUE_W-1:0]      t;
    logic signed [K_W-1:0] td;
    logic signed [K_W-1:0] td_abs;
    logic signed [A_W-1:0] two_l;
    logic signed [A_W-1:0] dl;
    logic signed [A_W-1:0] dl_abs;
    logic signed [A_W-1:0] n_a;
    logic signed [K_W-1:0] n_k;
    t_sel_set              n_sel;

    logic                  r_valid;
    logic signed [A_W-1:0] r_a;
    logic [UNIT_W-1:0]     r_s;
    logic [UNIT_W-1:0]     r_l;
    logic signed [K_W-1:0] r_k;
    t_sel_set              r_sel;

    // Hue modulo 120 degrees; hues past 360 degrees still wrap here.
    always_comb begin
        priority if (i_req.hue >= TH8) begin
            t = i_req.hue - TH8;
        end else if (i_req.hue >= TH6) begin
            t = i_req.hue - TH6;
        end else if (i_req.hue >= TH4) begin
            t = i_req.hue - TH4;
        end else if (i_req.hue >= TH2) begin
            t = i_req.hue - TH2;
        end else begin
            t = i_req.hue;
        end
    end

    // The X weight is folded into k = D - 2|t - D|, which lies in -D..D.
    assign td     = signed'(K_W'(t)) - K_SECTOR;
    assign td_abs = td[K_W-1] ? -td : td;
    assign n_k    = K_SECTOR - (td_abs <<< 1);

    assign two_l  = signed'({1'b0, i_req.lightness, 1'b0});
    assign dl     = two_l - A_UNIT;
    assign dl_abs = dl[A_W-1] ? -dl : dl;
    assign n_a    = A_UNIT - dl_abs;

    // Anything at or past the fifth boundary lands in the last sector.
    always_comb begin
        priority if (i_req.hue < TH1) begin
            n_sel = '{red: SEL_C, green: SEL_X, blue: SEL_ZERO};
        end else if (i_req.hue < TH2) begin
            n_sel = '{red: SEL_X, green: SEL_C, blue: SEL_ZERO};
        end else if (i_req.hue < TH3) begin
            n_sel = '{red: SEL_ZERO, green: SEL_C, blue: SEL_X};
        end else if (i_req.hue < TH4) begin
            n_sel = '{red: SEL_ZERO, green: SEL_X, blue: SEL_C};
        end else if (i_req.hue < TH5) begin
            n_sel = '{red: SEL_X, green: SEL_ZERO, blue: SEL_C};
        end else begin
            n_sel = '{red: SEL_C, green: SEL_ZERO, blue: SEL_X};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a   <= n_a;
        r_s   <= i_req.saturation;
        r_l   <= i_req.lightness;
        r_k   <= n_k;
        r_sel <= n_sel;
    end

    assign o_stage = '{valid: r_valid, a: r_a, s: r_s, l: r_l, k: r_k, sel: r_sel};

    a_one_chroma: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> $onehot({r_sel.red == SEL_C, r_sel.green == SEL_C,
                             r_sel.blue == SEL_C}))
        else $error("chroma not placed on exactly one channel");

    a_one_second: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> $onehot({r_sel.red == SEL_X, r_sel.green == SEL_X,
                             r_sel.blue == SEL_X}))
        else $error("secondary not placed on exactly one channel");

endmodule

[rtl/hsl2rgb_product.sv]
module hsl2rgb_product (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  hsl2rgb_pkg::t_front_stage i_stage,
    output hsl2rgb_pkg::t_prod_stage  o_stage
);
    import hsl2rgb_pkg::*;

    localparam logic signed [N_W-1:0] N_SECTOR = N_W'(SECTOR);

    logic signed [A_W+UNIT_W:0]   cn_full;
    logic signed [CN_W+K_W-1:0]   p_full;
    logic signed [CN_W-1:0]       n_cn;
    logic signed [N_W-1:0]        n_p;
    logic signed [N_W-1:0]        n_cd;
    logic signed [N_W-1:0]        n_base;

    logic                  r_valid2;
    logic signed [CN_W-1:0] r_cn;
    logic signed [K_W-1:0] r_k;
    logic [UNIT_W-1:0]     r_l;
    t_sel_set              r_sel2;

    logic                  r_valid3;
    logic signed [N_W-1:0] r_p;
    logic signed [N_W-1:0] r_cd;
    logic signed [N_W-1:0] r_base;
    t_sel_set              r_sel3;

    // Chroma numerator Cn = (U - |2L - U|) * S.
    assign cn_full = i_stage.a * signed'({1'b0, i_stage.s});
    assign n_cn    = CN_W'(cn_full);

    // Chroma, zero and X all share the lightness term 120 * L * 2^(F + HF).
    assign p_full = r_cn * r_k;
    assign n_p    = N_W'(p_full);
    assign n_cd   = N_W'(r_cn) * N_SECTOR;
    assign n_base = signed'((N_W'(r_l) * N_W'(LIGHT_SCALE)) << BASE_SH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid2 <= 1'b0;
            r_valid3 <= 1'b0;
        end else begin
            r_valid2 <= i_stage.valid;
            r_valid3 <= r_valid2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cn   <= n_cn;
        r_k    <= i_stage.k;
        r_l    <= i_stage.l;
        r_sel2 <= i_stage.sel;
        r_p    <= n_p;
        r_cd   <= n_cd;
        r_base <= n_base;
        r_sel3 <= r_sel2;
    end

    assign o_stage = '{valid: r_valid3, p: r_p, cd: r_cd, base: r_base, sel: r_sel3};

endmodule

[rtl/hsl2rgb_channel.sv]
module hsl2rgb_channel (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    input  hsl2rgb_pkg::t_comp_sel                i_sel,
    input  logic signed [hsl2rgb_pkg::N_W-1:0]    i_p,
    input  logic signed [hsl2rgb_pkg::N_W-1:0]    i_cd,
    input  logic signed [hsl2rgb_pkg::N_W-1:0]    i_base,
    output logic                                  o_valid,
    output logic [hsl2rgb_pkg::CHAN_W-1:0]        o_value
);
    import hsl2rgb_pkg::*;

    localparam logic signed [Q_W-1:0] Q_MAX = Q_W'(CHAN_MAX);

    logic signed [N_W-1:0] comp;
    logic signed [N_W-1:0] n_num;
    logic signed [M_W-1:0] m_ext;
    logic signed [M_W-1:0] scaled;
    logic signed [Q_W-1:0] q;
    logic [CHAN_W-1:0]     n_value;

    logic                  r_valid4;
    logic signed [N_W-1:0] r_num;
    logic                  r_valid5;
    logic [CHAN_W-1:0]     r_value;

    always_comb begin
        unique case (i_sel)
            SEL_C:    comp = i_cd;
            SEL_X:    comp = i_p;
            SEL_ZERO: comp = -i_cd;
            default:  comp = -i_cd;
        endcase
    end

    assign n_num = comp + i_base;

    // Times 17, then a floor shift; a negative quotient clamps to zero either way.
    assign m_ext  = M_W'(r_num);
    assign scaled = (m_ext <<< 4) + m_ext;
    assign q      = signed'(scaled[M_W-1:OUT_SHIFT]);

    always_comb begin
        priority if (q[Q_W-1]) begin
            n_value = '0;
        end else if (q > Q_MAX) begin
            n_value = CHAN_W'(CHAN_MAX);
        end else begin
            n_value = q[CHAN_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid4 <= 1'b0;
            r_valid5 <= 1'b0;
        end else begin
            r_valid4 <= i_valid;
            r_valid5 <= r_valid4;
        end
    end

    always_ff @(posedge i_clk) begin
        r_num   <= n_num;
        r_value <= n_value;
    end

    assign o_valid = r_valid5;
    assign o_value = r_value;

endmodule

[rtl/hsl_to_rgb_converter.sv]
// HSL to RGB color converter.
//
// Requests: present hue, saturation and lightness on i_req and raise start.
// A request is taken at every rising edge with start high and busy low; busy
// is always low, so one request can be taken in every clock cycle.
// Results: o_result carries red, green and blue for exactly one cycle, marked
// by o_strobe, once the request has passed every pipeline stage. Results come
// out in request order, one per request, and the receiver takes each one in
// the cycle it is shown; there is no back pressure. The pipeline has five
// register stages: input decode and hue sector, the chroma multiplier, the
// secondary-component multiplier, channel selection with the lightness
// offset, and the final scaling by 255 with clamping. Each channel is
// truncated toward zero and held to 0..255. Throughput is one color per clock.
// Reset (synchronous, active low) clears the valid bits of every stage, so
// requests still in flight are dropped and no strobe follows until a new
// request is taken.
module hsl_to_rgb_converter (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  hsl2rgb_pkg::t_hsl_req    i_req,
    output logic                     o_strobe,
    output hsl2rgb_pkg::t_rgb_result o_result
);
    import hsl2rgb_pkg::*;

    t_front_stage      front;
    t_prod_stage       prod;
    logic              accept;
    logic              red_valid;
    logic              green_valid;
    logic              blue_valid;
    logic [CHAN_W-1:0] red_value;
    logic [CHAN_W-1:0] green_value;
    logic [CHAN_W-1:0] blue_value;

    // The pipeline never stalls, so a request is always welcome.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    hsl2rgb_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_req   (i_req),
        .o_stage (front)
    );

    hsl2rgb_product u_product (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stage (front),
        .o_stage (prod)
    );

    hsl2rgb_channel u_red (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (prod.valid),
        .i_sel   (prod.sel.red),
        .i_p     (prod.p),
        .i_cd    (prod.cd),
        .i_base  (prod.base),
        .o_valid (red_valid),
        .o_value (red_value)
    );

    hsl2rgb_channel u_green (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (prod.valid),
        .i_sel   (prod.sel.green),
        .i_p     (prod.p),
        .i_cd    (prod.cd),
        .i_base  (prod.base),
        .o_valid (green_valid),
        .o_value (green_value)
    );

    hsl2rgb_channel u_blue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (prod.valid),
        .i_sel   (prod.sel.blue),
        .i_p     (prod.p),
        .i_cd    (prod.cd),
        .i_base  (prod.base),
        .o_valid (blue_valid),
        .o_value (blue_value)
    );

    assign o_strobe = red_valid;
    assign o_result = '{red: red_value, green: green_value, blue: blue_value};

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##5 o_strobe)
        else $error("request did not produce a result after five cycles");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(accept, 5))
        else $error("result strobe without a matching request");

    a_lanes_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        red_valid == green_valid && red_valid == blue_valid)
        else $error("channel lanes out of step");

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import hsl2rgb_pkg::*;

    localparam int NUM_RANDOM    = 1700;
    localparam int IDLE_PERCENT  = 37;
    localparam int QUIET_FIRST   = 600;
    localparam int QUIET_LAST    = 1000;
    localparam int DRAIN_LIMIT   = 1000;
    localparam int PIPE_LATENCY  = 5;
    localparam int HUE_IN_RANGE  = 360 * (1 << HUE_FRAC_BITS) - 1;

    class rgb_scoreboard;
        t_rgb_result rgb_expected[$];
        int          errors;

        function new();
            errors = 0;
        endfunction

        static function longint magnitude(longint v);
            return (v < 0) ? -v : v;
        endfunction

        // Truncates toward zero, then holds the channel to 0..255.
        static function logic [CHAN_W-1:0] to_chan(longint comp, longint offs, longint den);
            longint q;
            q = ((comp + offs) * 255) / den;
            if (q < 0)
                q = 0;
            if (q > 255)
                q = 255;
            return q[CHAN_W-1:0];
        endfunction

        // Exact HSL to RGB conversion over one common denominator.
        static function t_rgb_result rgb_of(t_hsl_req req);
            t_rgb_result res;
            longint      unit, sect, den;
            longint      h, s, l, cn, t, c_num, x_num, m_num;
            longint      r, g, b;
            unit  = longint'(1) << UNIT_FRAC_BITS;
            sect  = longint'(60) << HUE_FRAC_BITS;
            den   = 2 * unit * unit * sect;
            h     = longint'(req.hue);
            s     = longint'(req.saturation);
            l     = longint'(req.lightness);
            cn    = (unit - magnitude(2 * l - unit)) * s;
            t     = h % (2 * sect);
            c_num = 2 * sect * cn;
            x_num = 2 * cn * (sect - magnitude(t - sect));
            m_num = 2 * sect * unit * l - sect * cn;
            if (h < sect) begin
                r = c_num; g = x_num; b = 0;
            end else if (h < 2 * sect) begin
                r = x_num; g = c_num; b = 0;
            end else if (h < 3 * sect) begin
                r = 0; g = c_num; b = x_num;
            end else if (h < 4 * sect) begin
                r = 0; g = x_num; b = c_num;
            end else if (h < 5 * sect) begin
                r = x_num; g = 0; b = c_num;
            end else begin
                // Hues at or past 360 degrees also land in the last sector.
                r = c_num; g = 0; b = x_num;
            end
            res.red   = to_chan(r, m_num, den);
            res.green = to_chan(g, m_num, den);
            res.blue  = to_chan(b, m_num, den);
            return res;
        endfunction

        function void note_request(t_hsl_req req);
            rgb_expected.push_back(rgb_of(req));
        endfunction

        function void check_chan(string name, logic [CHAN_W-1:0] exp_v,
                                 logic [CHAN_W-1:0] act_v);
            if (act_v !== exp_v) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, exp_v, act_v);
            end
        endfunction

        function void check_result(t_rgb_result act);
            t_rgb_result exp_r;
            if (rgb_expected.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual %0d/%0d/%0d",
                         $time, act.red, act.green, act.blue);
                return;
            end
            exp_r = rgb_expected.pop_front();
            check_chan("red", exp_r.red, act.red);
            check_chan("green", exp_r.green, act.green);
            check_chan("blue", exp_r.blue, act.blue);
        endfunction

        function int pending();
            return rgb_expected.size();
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_hsl_req    i_req;
    logic        o_strobe;
    t_rgb_result o_result;

    rgb_scoreboard sb = new();

    hsl_to_rgb_converter DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_req    (i_req),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_strobe === 1'b1)
            sb.check_result(o_result);
    end

    function automatic t_hsl_req make_hsl(int unsigned hue, int unsigned sat, int unsigned lit);
        t_hsl_req r;
        r.hue        = hue[HUE_W-1:0];
        r.saturation = sat[UNIT_W-1:0];
        r.lightness  = lit[UNIT_W-1:0];
        return r;
    endfunction

    // Mostly legal colors; the rest uses every bit of every field.
    function automatic t_hsl_req random_hsl();
        if ($urandom_range(0, 99) < 70)
            return make_hsl($urandom_range(0, HUE_IN_RANGE),
                            $urandom_range(0, UNIT_ONE), $urandom_range(0, UNIT_ONE));
        return make_hsl($urandom, $urandom, $urandom);
    endfunction

    // Holds the request on the ports until an edge takes it.
    task automatic send_request(t_hsl_req req);
        i_req <= req;
        start <= 1'b1;
        do
            @(posedge i_clk);
        while (busy !== 1'b0);
        sb.note_request(req);
    endtask

    task automatic idle_cycle();
        start <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_with_gaps(t_hsl_req req, bit quiet);
        while (!quiet && $urandom_range(0, 99) < IDLE_PERCENT)
            idle_cycle();
        send_request(req);
    endtask

    initial begin
        t_hsl_req directed[$];
        int       waited;
        i_rst_n <= 1'b0;
        start   <= 1'b0;
        i_req   <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Sector edges, hue extremes and out-of-range hues.
        directed.push_back(make_hsl(0, UNIT_ONE, UNIT_ONE / 2));
        directed.push_back(make_hsl(SECTOR - 1, UNIT_ONE, UNIT_ONE / 2));
        directed.push_back(make_hsl(SECTOR, UNIT_ONE, UNIT_ONE / 2));
        directed.push_back(make_hsl(2 * SECTOR, UNIT_ONE, UNIT_ONE / 2));
        directed.push_back(make_hsl(3 * SECTOR, UNIT_ONE, UNIT_ONE / 2));
        directed.push_back(make_hsl(4 * SECTOR, UNIT_ONE, UNIT_ONE / 2));
        directed.push_back(make_hsl(5 * SECTOR, UNIT_ONE, UNIT_ONE / 2));
        directed.push_back(make_hsl(HUE_IN_RANGE, UNIT_ONE, UNIT_ONE / 2));
        directed.push_back(make_hsl(6 * SECTOR, UNIT_ONE, UNIT_ONE / 2));
        directed.push_back(make_hsl(6 * SECTOR + SECTOR / 2, UNIT_ONE, UNIT_ONE / 3));
        directed.push_back(make_hsl((1 << HUE_W) - 1, UNIT_ONE, UNIT_ONE / 2));
        // Gray, black and white.
        directed.push_back(make_hsl(SECTOR / 2, 0, UNIT_ONE / 2));
        directed.push_back(make_hsl(SECTOR / 2, UNIT_ONE, 0));
        directed.push_back(make_hsl(SECTOR / 2, UNIT_ONE, UNIT_ONE));
        directed.push_back(make_hsl(0, 0, 0));
        directed.push_back(make_hsl(HUE_IN_RANGE, UNIT_ONE, UNIT_ONE));
        // Saturation or lightness above one, where chroma can go negative, and a mid-range color.
        directed.push_back(make_hsl(SECTOR / 2, (1 << UNIT_W) - 1, UNIT_ONE / 2));
        directed.push_back(make_hsl(SECTOR / 2, UNIT_ONE, (1 << UNIT_W) - 1));
        directed.push_back(make_hsl(3 * SECTOR + 7, (1 << UNIT_W) - 1, (1 << UNIT_W) - 1));
        directed.push_back(make_hsl((1 << HUE_W) - 1, (1 << UNIT_W) - 1, (1 << UNIT_W) - 1));
        directed.push_back(make_hsl(2 * SECTOR + 1, UNIT_ONE + 1, UNIT_ONE / 4));
        directed.push_back(make_hsl(4 * SECTOR - 1, UNIT_ONE / 2, 3 * UNIT_ONE / 4));

        foreach (directed[i])
            send_with_gaps(directed[i], 1'b0);

        for (int n = 0; n < NUM_RANDOM; n++)
            send_with_gaps(random_hsl(), n >= QUIET_FIRST && n < QUIET_LAST);
        start <= 1'b0;

        waited = 0;
        while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (2 * PIPE_LATENCY) @(posedge i_clk);

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            if (sb.pending() != 0)
                $display("%0t: %0d results never arrived", $time, sb.pending());
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #1ms;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

[hsl_to_rgb_converter.f]
rtl/hsl2rgb_pkg.sv
rtl/hsl2rgb_front.sv
rtl/hsl2rgb_product.sv
rtl/hsl2rgb_channel.sv
rtl/hsl_to_rgb_converter.sv
dv/tb_top.sv
